// ===== hdl/opd_pkg.sv =====
// Shared types, codes and lookup functions for the OBD mode-01 reply decoder.
package opd_pkg;

    // Supported PID indexes and count
    localparam logic [3:0] PID_RPM      = 4'd0;
    localparam logic [3:0] PID_SPEED    = 4'd1;
    localparam logic [3:0] PID_COOLANT  = 4'd2;
    localparam logic [3:0] PID_LOAD     = 4'd3;
    localparam logic [3:0] PID_MAF      = 4'd4;
    localparam logic [3:0] PID_THROTTLE = 4'd5;
    localparam logic [3:0] PID_VOLTAGE  = 4'd6;
    localparam logic [3:0] PID_FUEL     = 4'd7;
    localparam logic [3:0] PID_INTAKE   = 4'd8;
    localparam logic [3:0] PID_COUNT    = 4'd9;

    // Reply status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_HEADER = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;

    // Mode-01 response service byte
    localparam logic [7:0] MODE01_REPLY = 8'h41;

    // floor(2^32 / 255), underestimates 1/255 so the quotient is never high
    localparam logic [24:0] RECIP_255 = 25'h101_0101;

    // One finished reply handed from the front to the back
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] pid;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } t_job;

    // Wire code of each PID index (zero for unknown indexes)
    function automatic logic [7:0] pid_code(input logic [3:0] idx);
        logic [7:0] code;
        unique case (idx)
            PID_RPM:      code = 8'h0C;
            PID_SPEED:    code = 8'h0D;
            PID_COOLANT:  code = 8'h05;
            PID_LOAD:     code = 8'h04;
            PID_MAF:      code = 8'h10;
            PID_THROTTLE: code = 8'h11;
            PID_VOLTAGE:  code = 8'h42;
            PID_FUEL:     code = 8'h2F;
            PID_INTAKE:   code = 8'h0F;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

    // Data bytes a PID needs
    function automatic logic [1:0] pid_need(input logic [3:0] idx);
        logic [1:0] need;
        unique case (idx) inside
            PID_RPM, PID_MAF, PID_VOLTAGE: need = 2'd2;
            default:                       need = 2'd1;
        endcase
        return need;
    endfunction

endpackage

// ===== hdl/opd_front.sv =====
// Front end: hex filter, header search and data byte assembly per character.
module opd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_char_code,
    input  logic [3:0]    i_pid_index,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output opd_pkg::t_job o_job
);
    import opd_pkg::*;

    logic [11:0] r_window, n_window;
    logic [1:0]  r_seen,   n_seen;
    logic        r_hdr,    n_hdr;
    logic [3:0]  r_nib,    n_nib;
    logic        r_pend,   n_pend;
    logic [1:0]  r_bytes,  n_bytes;
    logic [7:0]  r_a,      n_a;
    logic [7:0]  r_b,      n_b;

    logic       is_hex;
    logic [3:0] digit;
    logic       hdr_match;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && i_last;

    // ASCII hex digit decode, both letter cases
    always_comb begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (i_char_code >= "0" && i_char_code <= "9") begin
            digit = 4'(i_char_code - "0");
        end else if (i_char_code >= "A" && i_char_code <= "F") begin
            digit = 4'(i_char_code - "A" + 8'd10);
        end else if (i_char_code >= "a" && i_char_code <= "f") begin
            digit = 4'(i_char_code - "a" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Header test: three digits held plus this one
    assign hdr_match = (r_seen == 2'd3) && (i_pid_index < PID_COUNT) &&
                       ({r_window, digit} == {MODE01_REPLY, pid_code(i_pid_index)});

    // Next state after taking this character
    always_comb begin
        n_window = r_window;
        n_seen   = r_seen;
        n_hdr    = r_hdr;
        n_nib    = r_nib;
        n_pend   = r_pend;
        n_bytes  = r_bytes;
        n_a      = r_a;
        n_b      = r_b;
        if (is_hex) begin
            if (r_hdr) begin
                if (!r_pend) begin
                    n_nib  = digit;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (r_bytes == 2'd0) begin
                        n_a     = {r_nib, digit};
                        n_bytes = 2'd1;
                    end else if (r_bytes == 2'd1) begin
                        n_b     = {r_nib, digit};
                        n_bytes = 2'd2;
                    end
                end
            end else if (hdr_match) begin
                n_hdr = 1'b1;
            end else begin
                n_window = {r_window[7:0], digit};
                if (r_seen != 2'd3) begin
                    n_seen = r_seen + 2'd1;
                end
            end
        end
    end

    // Reply summary, formed from the state including the final character
    always_comb begin
        o_job.pid    = i_pid_index;
        o_job.byte_a = n_a;
        o_job.byte_b = n_b;
        if (!n_hdr || i_pid_index >= PID_COUNT) begin
            o_job.status = STATUS_NO_HEADER;
        end else if (n_bytes < pid_need(i_pid_index)) begin
            o_job.status = STATUS_SHORT;
        end else begin
            o_job.status = STATUS_OK;
        end
    end

    // State update; the final character clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_window <= '0;
            r_seen   <= '0;
            r_hdr    <= 1'b0;
            r_nib    <= '0;
            r_pend   <= 1'b0;
            r_bytes  <= '0;
            r_a      <= '0;
            r_b      <= '0;
        end else if (accept) begin
            r_window <= n_window;
            r_seen   <= n_seen;
            r_hdr    <= n_hdr;
            r_nib    <= n_nib;
            r_pend   <= n_pend;
            r_bytes  <= n_bytes;
            r_a      <= n_a;
            r_b      <= n_b;
        end
    end

endmodule

// ===== hdl/opd_queue.sv =====
// Two-entry queue of finished replies between the front and the back.
module opd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  opd_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output opd_pkg::t_job o_job
);
    import opd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue read while empty");

endmodule

// ===== hdl/opd_back.sv =====
// Back end: scaling multiply, divide by 255 through a reciprocal, output register.
module opd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  opd_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_status,
    output logic signed [24:0]  o_value_milli
);
    import opd_pkg::*;

    // Stage 1: scaled product
    logic               r_v1;
    logic [1:0]         r_st1;
    logic               r_div1;
    logic signed [25:0] r_prod1;
    // Stage 2: quotient estimate
    logic               r_v2;
    logic [1:0]         r_st2;
    logic               r_div2;
    logic signed [25:0] r_prod2;
    logic [17:0]        r_q2;
    // Stage 3: output register
    logic               r_v3;

    logic ready1, ready2, ready3;

    logic signed [17:0] operand;
    logic [17:0]        factor;
    logic               use_div;
    logic [15:0]        word;
    logic signed [36:0] prod_full;
    logic [49:0]        recip_full;
    logic [25:0]        rem;
    logic [17:0]        q_fix;

    assign ready3 = !r_v3 || !i_stall;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;
    assign o_pop  = i_valid && ready1;
    assign o_valid = r_v3;

    // Operand and scale factor per PID
    assign word = {i_job.byte_a, i_job.byte_b};
    always_comb begin
        operand = '0;
        factor  = '0;
        use_div = 1'b0;
        unique case (i_job.pid) inside
            PID_RPM: begin
                operand = {2'b00, word};
                factor  = 18'd250;
            end
            PID_SPEED: begin
                operand = {10'd0, i_job.byte_a};
                factor  = 18'd1000;
            end
            PID_COOLANT, PID_INTAKE: begin
                operand = {10'd0, i_job.byte_a} - 18'sd40;
                factor  = 18'd1000;
            end
            PID_LOAD, PID_THROTTLE, PID_FUEL: begin
                operand = {10'd0, i_job.byte_a};
                factor  = 18'd100000;
                use_div = 1'b1;
            end
            PID_MAF: begin
                operand = {2'b00, word};
                factor  = 18'd10;
            end
            PID_VOLTAGE: begin
                operand = {2'b00, word};
                factor  = 18'd1;
            end
            default: begin
                operand = '0;
                factor  = '0;
            end
        endcase
        if (i_job.status != STATUS_OK) begin
            operand = '0;
            use_div = 1'b0;
        end
    end

    assign prod_full = operand * $signed({1'b0, factor});

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ready1) begin
            r_v1 <= i_valid;
        end
        if (ready1 && i_valid) begin
            r_st1   <= i_job.status;
            r_div1  <= use_div;
            r_prod1 <= prod_full[25:0];
        end
    end

    // Quotient estimate: never high, at most one low
    assign recip_full = {25'd0, r_prod1[24:0]} * {25'd0, RECIP_255};

    // Stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
        if (ready2 && r_v1) begin
            r_st2   <= r_st1;
            r_div2  <= r_div1;
            r_prod2 <= r_prod1;
            r_q2    <= recip_full[49:32];
        end
    end

    // Remainder check fixes the estimate
    assign rem   = 26'(r_prod2) - ({8'd0, r_q2} << 8) + {8'd0, r_q2};
    assign q_fix = (rem >= 26'd255) ? r_q2 + 18'd1 : r_q2;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= r_v2;
        end
        if (ready3 && r_v2) begin
            o_status      <= r_st2;
            o_value_milli <= r_div2 ? $signed({7'd0, q_fix}) : r_prod2[24:0];
        end
    end

    zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STATUS_OK) |-> (o_value_milli == 25'sd0))
        else $error("nonzero value with error status");

    status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_NO_HEADER ||
                     o_status == STATUS_SHORT))
        else $error("undefined status code");

endmodule

// ===== hdl/obd_pid_reply_decoder_unit.sv =====
// Top level of the OBD mode-01 PID reply decoder.
// Throughput: one character per cycle while o_stall is low; back-to-back replies are
// taken without gaps. The final character's reply then passes the queue, product stage,
// quotient stage and output register, and takes longer under stall.
// The front stalls only when the two-entry reply queue is full.
// Reset (synchronous, active low) clears all reply state, the queue and the pipe valids.
module obd_pid_reply_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic [3:0]         i_pid_index,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [24:0] o_value_milli
);
    import opd_pkg::*;

    logic q_full, q_valid, push, pop;
    t_job front_job, queue_job;

    // Character front end
    opd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_pid_index (i_pid_index),
        .i_last      (i_last),
        .i_full      (q_full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_job       (front_job)
    );

    // Reply queue
    opd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (queue_job)
    );

    // Scaling back end
    opd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_job         (queue_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_value_milli (o_value_milli)
    );

endmodule
